FILE: design/pkat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pkat_pkg;

    // table geometry
    localparam int DEPTH   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // id handling: ids travel on 8-bit fields, only the low ID_BITS bits count
    localparam int ID_W    = 8;
    localparam int ID_BITS = 8;
    localparam logic [ID_W-1:0] ID_MASK = ID_W'((1 << ID_BITS) - 1);

    // amount and result widths
    localparam int AMT_IN_W = 16;
    localparam int AMT_W    = 20;
    localparam int SUM_W    = 25;
    localparam int VAL_W    = 26;
    localparam logic [AMT_W-1:0] AMT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [VAL_W-1:0] VAL_NOT_FOUND = '1;

    // stream widths
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [3:0] {
        OP_CLEAR    = 4'd0,
        OP_ADD      = 4'd1,
        OP_APPEND   = 4'd2,
        OP_REMOVE   = 4'd3,
        OP_LOOKUP   = 4'd4,
        OP_SUM_SRC  = 4'd5,
        OP_SUM_DST  = 4'd6,
        OP_LIST_SRC = 4'd7,
        OP_LIST_DST = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        MODE_PAIR = 2'd0,
        MODE_SRC  = 2'd1,
        MODE_DST  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [ID_W-1:0]  src;
        logic [ID_W-1:0]  dst;
        logic [AMT_W-1:0] amount;
    } t_entry;

    typedef struct packed {
        logic shift_in;   // take the entry of the next cell up the chain
        logic load_new;   // take the broadcast entry
        logic amt_only;   // take only the broadcast amount
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: design/pkat_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pkat_cell (
    input  wire logic                      i_clk,
    input  wire pkat_pkg::t_cell_ctl       i_ctl,
    input  wire pkat_pkg::t_entry          i_new,
    input  wire pkat_pkg::t_entry          i_nbr,
    input  wire logic [pkat_pkg::ID_W-1:0] i_key_src,
    input  wire logic [pkat_pkg::ID_W-1:0] i_key_dst,
    input  wire pkat_pkg::t_mode           i_mode,
    output pkat_pkg::t_entry               o_entry,
    output logic                           o_match
);

    pkat_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_in) begin
            r_entry <= i_nbr;
        end else if (i_ctl.load_new) begin
            r_entry <= i_new;
        end else if (i_ctl.amt_only) begin
            r_entry.amount <= i_new.amount;
        end
    end

    always_comb begin
        unique case (i_mode)
            pkat_pkg::MODE_PAIR: o_match = (r_entry.src == i_key_src) &&
                                           (r_entry.dst == i_key_dst);
            pkat_pkg::MODE_SRC:  o_match = (r_entry.src == i_key_src);
            pkat_pkg::MODE_DST:  o_match = (r_entry.dst == i_key_dst);
            default:             o_match = 1'b0;
        endcase
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

FILE: design/pkat_row.sv
`timescale 1ns / 1ps
`default_nettype none

module pkat_row (
    input  wire logic                                    i_clk,
    input  wire pkat_pkg::t_cell_ctl [pkat_pkg::DEPTH-1:0] i_ctl,
    input  wire pkat_pkg::t_entry                        i_new,
    input  wire logic [pkat_pkg::ID_W-1:0]               i_key_src,
    input  wire logic [pkat_pkg::ID_W-1:0]               i_key_dst,
    input  wire pkat_pkg::t_mode                         i_mode,
    input  wire logic [pkat_pkg::DEPTH-1:0]              i_sel,
    output logic [pkat_pkg::DEPTH-1:0]                   o_match,
    output pkat_pkg::t_entry                             o_sel_entry
);

    pkat_pkg::t_entry w_entry [pkat_pkg::DEPTH];

    // cell i hands its entry down to cell i-1; the top cell feeds itself
    for (genvar gi = 0; gi < pkat_pkg::DEPTH; gi++) begin : g_cell
        pkat_pkg::t_entry w_nbr;

        if (gi == pkat_pkg::DEPTH - 1) begin : g_top
            assign w_nbr = w_entry[gi];
        end else begin : g_mid
            assign w_nbr = w_entry[gi + 1];
        end

        pkat_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl[gi]),
            .i_new     (i_new),
            .i_nbr     (w_nbr),
            .i_key_src (i_key_src),
            .i_key_dst (i_key_dst),
            .i_mode    (i_mode),
            .o_entry   (w_entry[gi]),
            .o_match   (o_match[gi])
        );
    end

    // one-hot select of a single entry
    always_comb begin
        o_sel_entry = '0;
        for (int i = 0; i < pkat_pkg::DEPTH; i++) begin
            if (i_sel[i]) begin
                o_sel_entry = pkat_pkg::t_entry'(o_sel_entry | w_entry[i]);
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/pair_keyed_accumulate_table.sv
// request to result: clear, append and unknown codes go straight to the apply step; add, remove,
//   lookup pass the match, pick and apply steps; sums and lists pass the match, pick and scan steps,
//   lists giving one entry per cycle while the result side does not stall
// throughput: one request at a time through the match, pick, apply and scan steps over the cell row;
//   the next request is taken once the last result of the previous one enters the result register
// reset: synchronous, active low; empties the table and drops any pending result
`timescale 1ns / 1ps
`default_nettype none

module pair_keyed_accumulate_table (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // request stream
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    // [7:0] source_region, [15:8] dest_region, [31:16] amount
    input  wire logic [pkat_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // [3:0] operation
    input  wire logic [pkat_pkg::IN_USER_W-1:0]       i_s_tuser,
    // result stream
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    // [25:0] value, [33:26] item_source, [41:34] item_dest,
    // [61:42] item_amount, [62] found, [63] status
    output logic [pkat_pkg::OUT_DATA_W-1:0]           o_m_tdata,
    output logic                                      o_m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_PICK,
        S_APPLY,
        S_SCAN
    } t_state;

    localparam int DEPTH = pkat_pkg::DEPTH;
    localparam int CNT_W = pkat_pkg::CNT_W;
    localparam int AMT_W = pkat_pkg::AMT_W;
    localparam int SUM_W = pkat_pkg::SUM_W;
    localparam int VAL_W = pkat_pkg::VAL_W;
    localparam int ID_W  = pkat_pkg::ID_W;

    // control state
    t_state                      r_state;
    logic [CNT_W-1:0]            r_count;
    logic                        r_out_valid;

    // request being worked on
    logic [3:0]                  r_op;
    logic [ID_W-1:0]             r_src;
    logic [ID_W-1:0]             r_dst;
    logic [pkat_pkg::AMT_IN_W-1:0] r_amt;

    // match bookkeeping
    logic [DEPTH-1:0]            r_match;   // matches not yet picked
    logic [DEPTH-1:0]            r_sel;     // one-hot entry being used
    logic                        r_any;
    logic [SUM_W-1:0]            r_sum;

    // result register
    logic [VAL_W-1:0]            r_out_value;
    logic [ID_W-1:0]             r_out_src;
    logic [ID_W-1:0]             r_out_dst;
    logic [AMT_W-1:0]            r_out_amount;
    logic                        r_out_found;
    logic                        r_out_status;
    logic                        r_out_last;

    // request fields
    logic [3:0]                  w_in_op;
    logic [ID_W-1:0]             w_in_src;
    logic [ID_W-1:0]             w_in_dst;
    logic [pkat_pkg::AMT_IN_W-1:0] w_in_amt;

    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_out_load;
    logic                        w_full;
    logic                        w_is_sum;
    logic                        w_is_scan;
    pkat_pkg::t_mode             w_mode;

    logic [DEPTH-1:0]            w_match;
    logic [DEPTH-1:0]            w_below;
    logic [DEPTH-1:0]            w_at_count;
    logic [DEPTH-1:0]            w_first;
    logic [DEPTH-1:0]            w_from_sel;

    pkat_pkg::t_entry            w_sel_entry;
    pkat_pkg::t_entry            w_new;
    pkat_pkg::t_cell_ctl [DEPTH-1:0] w_ctl;

    logic [AMT_W:0]              w_merge_raw;
    logic [AMT_W-1:0]            w_merged;
    logic [SUM_W:0]              w_sum_raw;
    logic [SUM_W-1:0]            w_sum_next;

    assign w_in_src = i_s_tdata[7:0] & pkat_pkg::ID_MASK;
    assign w_in_dst = i_s_tdata[15:8] & pkat_pkg::ID_MASK;
    assign w_in_amt = i_s_tdata[31:16];
    assign w_in_op  = i_s_tuser;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_full     = (r_count == CNT_W'(DEPTH));

    // a new result enters the result register this cycle
    assign w_out_load = w_out_free &&
                        ((r_state == S_APPLY) ||
                         ((r_state == S_SCAN) && !(w_is_sum && (r_sel != '0))));

    // how the cells compare their entry against the request key
    always_comb begin
        w_is_sum  = 1'b0;
        w_is_scan = 1'b0;
        w_mode    = pkat_pkg::MODE_PAIR;
        case (r_op) inside
            pkat_pkg::OP_SUM_SRC: begin
                w_is_sum  = 1'b1;
                w_is_scan = 1'b1;
                w_mode    = pkat_pkg::MODE_SRC;
            end
            pkat_pkg::OP_SUM_DST: begin
                w_is_sum  = 1'b1;
                w_is_scan = 1'b1;
                w_mode    = pkat_pkg::MODE_DST;
            end
            pkat_pkg::OP_LIST_SRC: begin
                w_is_scan = 1'b1;
                w_mode    = pkat_pkg::MODE_SRC;
            end
            pkat_pkg::OP_LIST_DST: begin
                w_is_scan = 1'b1;
                w_mode    = pkat_pkg::MODE_DST;
            end
            default: begin
                w_mode = pkat_pkg::MODE_PAIR;
            end
        endcase
    end

    // live entries and the append slot
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_below[i]    = (CNT_W'(i) < r_count);
            w_at_count[i] = (CNT_W'(i) == r_count);
        end
    end

    // lowest remaining match, and every cell at or above the selected one
    assign w_first    = r_match & (~r_match + DEPTH'(1));
    assign w_from_sel = ~(r_sel - DEPTH'(1));

    // saturating merge and running sum
    assign w_merge_raw = {1'b0, w_sel_entry.amount} + (AMT_W + 1)'(r_amt);
    assign w_merged    = w_merge_raw[AMT_W] ? pkat_pkg::AMT_MAX : w_merge_raw[AMT_W-1:0];
    assign w_sum_raw   = {1'b0, r_sum} + (SUM_W + 1)'(w_sel_entry.amount);
    assign w_sum_next  = w_sum_raw[SUM_W] ? pkat_pkg::SUM_MAX : w_sum_raw[SUM_W-1:0];

    assign w_new.src    = r_src;
    assign w_new.dst    = r_dst;
    assign w_new.amount = r_any ? w_merged : AMT_W'(r_amt);

    // table writes all happen in the apply step
    always_comb begin
        w_ctl = '0;
        if (r_state == S_APPLY && w_out_free) begin
            for (int i = 0; i < DEPTH; i++) begin
                case (r_op)
                    pkat_pkg::OP_ADD: begin
                        w_ctl[i].amt_only = r_any && r_sel[i];
                        w_ctl[i].load_new = !r_any && !w_full && w_at_count[i];
                    end
                    pkat_pkg::OP_APPEND: begin
                        w_ctl[i].load_new = !w_full && w_at_count[i];
                    end
                    pkat_pkg::OP_REMOVE: begin
                        // close the gap: everything above the hit moves down one cell
                        w_ctl[i].shift_in = r_any && w_from_sel[i];
                    end
                    default: begin
                        w_ctl[i] = '0;
                    end
                endcase
            end
        end
    end

    pkat_row u_row (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_new       (w_new),
        .i_key_src   (r_src),
        .i_key_dst   (r_dst),
        .i_mode      (w_mode),
        .i_sel       (r_sel),
        .o_match     (w_match),
        .o_sel_entry (w_sel_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op  <= w_in_op;
                        r_src <= w_in_src;
                        r_dst <= w_in_dst;
                        r_amt <= w_in_amt;
                        r_sel <= '0;
                        r_any <= 1'b0;
                        r_sum <= '0;
                        case (w_in_op) inside
                            pkat_pkg::OP_ADD, pkat_pkg::OP_REMOVE, pkat_pkg::OP_LOOKUP,
                            pkat_pkg::OP_SUM_SRC, pkat_pkg::OP_SUM_DST,
                            pkat_pkg::OP_LIST_SRC, pkat_pkg::OP_LIST_DST: begin
                                r_state <= S_MATCH;
                            end
                            default: begin
                                r_state <= S_APPLY;
                            end
                        endcase
                    end
                end

                S_MATCH: begin
                    r_match <= w_match & w_below;
                    r_state <= S_PICK;
                end

                S_PICK: begin
                    r_sel   <= w_first;
                    r_match <= r_match & ~w_first;
                    r_any   <= |r_match;
                    r_state <= w_is_scan ? S_SCAN : S_APPLY;
                end

                S_APPLY: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_src    <= '0;
                        r_out_dst    <= '0;
                        r_out_amount <= '0;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                        case (r_op)
                            pkat_pkg::OP_CLEAR: begin
                                r_count      <= '0;
                                r_out_value  <= '0;
                                r_out_found  <= 1'b0;
                                r_out_status <= 1'b0;
                            end
                            pkat_pkg::OP_ADD: begin
                                r_out_found  <= r_any;
                                r_out_status <= !r_any && w_full;
                                if (r_any) begin
                                    r_out_value <= VAL_W'(w_merged);
                                end else if (!w_full) begin
                                    r_count     <= r_count + CNT_W'(1);
                                    r_out_value <= VAL_W'(r_amt);
                                end else begin
                                    r_out_value <= '0;
                                end
                            end
                            pkat_pkg::OP_APPEND: begin
                                r_out_found  <= 1'b0;
                                r_out_status <= w_full;
                                if (!w_full) begin
                                    r_count     <= r_count + CNT_W'(1);
                                    r_out_value <= VAL_W'(r_amt);
                                end else begin
                                    r_out_value <= '0;
                                end
                            end
                            pkat_pkg::OP_REMOVE: begin
                                r_out_found  <= r_any;
                                r_out_status <= 1'b0;
                                if (r_any) begin
                                    r_count     <= r_count - CNT_W'(1);
                                    r_out_value <= VAL_W'(w_sel_entry.amount);
                                end else begin
                                    r_out_value <= '0;
                                end
                            end
                            pkat_pkg::OP_LOOKUP: begin
                                r_out_found  <= r_any;
                                r_out_status <= 1'b0;
                                if (r_any) begin
                                    r_out_value <= VAL_W'(w_sel_entry.amount);
                                end else begin
                                    r_out_value <= pkat_pkg::VAL_NOT_FOUND;
                                end
                            end
                            default: begin
                                r_out_value  <= '0;
                                r_out_found  <= 1'b0;
                                r_out_status <= 1'b0;
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    if (w_out_free) begin
                        if (r_sel != '0) begin
                            // use the picked entry and pick the next one
                            r_sel   <= w_first;
                            r_match <= r_match & ~w_first;
                            if (w_is_sum) begin
                                r_sum <= w_sum_next;
                            end else begin
                                r_out_valid  <= 1'b1;
                                r_out_value  <= '0;
                                r_out_src    <= w_sel_entry.src;
                                r_out_dst    <= w_sel_entry.dst;
                                r_out_amount <= w_sel_entry.amount;
                                r_out_found  <= 1'b1;
                                r_out_status <= 1'b0;
                                r_out_last   <= (r_match == '0);
                                if (r_match == '0) begin
                                    r_state <= S_IDLE;
                                end
                            end
                        end else begin
                            // sum finished, or a list with no match at all
                            r_out_valid  <= 1'b1;
                            r_out_value  <= w_is_sum ? VAL_W'(r_sum) : '0;
                            r_out_src    <= '0;
                            r_out_dst    <= '0;
                            r_out_amount <= '0;
                            r_out_found  <= w_is_sum && r_any;
                            r_out_status <= 1'b0;
                            r_out_last   <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {r_out_status, r_out_found, r_out_amount,
                         r_out_dst, r_out_src, r_out_value};

endmodule

`default_nettype wire

FILE: design/pkat_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pkat_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_s_tready,
    input wire logic                               o_m_tvalid,
    input wire logic                               i_m_tready,
    input wire logic [pkat_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input wire logic                               o_m_tlast
);

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // a dropped insert never reports a hit
    a_status_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[63] && o_m_tdata[62]))
        else $error("full status with found set");

    // only listed entries come before the last result of a request
    a_mid_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[62] && !o_m_tdata[63])
        else $error("non-final result that is not a listed entry");

    // no request is taken while a multi-result list is still in flight
    a_no_take_mid_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast && i_m_tready |-> !o_s_tready)
        else $error("request taken during a list");

endmodule

bind pair_keyed_accumulate_table pkat_checker u_pkat_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

FILE: verif/pkat_result_check.sv
`timescale 1ns / 1ps

module pkat_result_check (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request stream as seen at the block
    input  wire logic                               i_s_tvalid,
    input  wire logic                               i_s_tready,
    // [7:0] source_region, [15:8] dest_region, [31:16] amount
    input  wire logic [pkat_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [3:0] operation
    input  wire logic [pkat_pkg::IN_USER_W-1:0]     i_s_tuser,
    // result stream as seen at the block
    input  wire logic                               i_m_tvalid,
    input  wire logic                               i_m_tready,
    // [25:0] value, [33:26] item_source, [41:34] item_dest,
    // [61:42] item_amount, [62] found, [63] status
    input  wire logic [pkat_pkg::OUT_DATA_W-1:0]    i_m_tdata,
    input  wire logic                               i_m_tlast,
    output int                                      o_fail_count,
    output int                                      o_pending_count
);
    import pkat_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [ID_W-1:0]  item_src;
        logic [ID_W-1:0]  item_dst;
        logic [AMT_W-1:0] item_amt;
        logic             found;
        logic             last;
        logic             status;
    } t_reply;

    // shadow copy of the table
    logic [ID_W-1:0]  row_src [DEPTH];
    logic [ID_W-1:0]  row_dst [DEPTH];
    logic [AMT_W-1:0] row_amt [DEPTH];
    int               rows_used = 0;

    t_reply           pending_replies [$];
    int               mismatches = 0;

    function automatic int find_pair_row(input logic [ID_W-1:0] src, input logic [ID_W-1:0] dst);
        for (int i = 0; i < rows_used; i++)
            if (row_src[i] == src && row_dst[i] == dst)
                return i;
        return -1;
    endfunction

    // append one expected reply at the tail of the queue
    task automatic queue_reply(input t_reply rep);
        pending_replies = {pending_replies, rep};
    endtask

    // update the shadow table for one request and queue the replies it causes
    task automatic apply_table_request(input logic [3:0]          op,
                                       input logic [ID_W-1:0]     src_raw,
                                       input logic [ID_W-1:0]     dst_raw,
                                       input logic [AMT_IN_W-1:0] amt);
        logic [ID_W-1:0]  src;
        logic [ID_W-1:0]  dst;
        logic [AMT_W:0]   merged;
        logic [VAL_W-1:0] total;
        logic             match;
        logic             have_prev;
        int               idx;
        t_reply           r;
        t_reply           prev;
        src       = src_raw & ID_MASK;
        dst       = dst_raw & ID_MASK;
        r         = '0;
        r.last    = 1'b1;
        prev      = '0;
        have_prev = 1'b0;
        case (op)
            OP_CLEAR: begin
                rows_used = 0;
            end
            OP_ADD, OP_APPEND: begin
                idx = (op == OP_ADD) ? find_pair_row(src, dst) : -1;
                if (idx >= 0) begin
                    merged = row_amt[idx] + amt;
                    if (merged > {1'b0, AMT_MAX})
                        merged = {1'b0, AMT_MAX};
                    row_amt[idx] = merged[AMT_W-1:0];
                    r.value      = VAL_W'(row_amt[idx]);
                    r.found      = 1'b1;
                end else if (rows_used < DEPTH) begin
                    row_src[rows_used] = src;
                    row_dst[rows_used] = dst;
                    row_amt[rows_used] = AMT_W'(amt);
                    rows_used++;
                    r.value = VAL_W'(amt);
                end else begin
                    r.status = 1'b1;
                end
            end
            OP_REMOVE: begin
                idx = find_pair_row(src, dst);
                if (idx >= 0) begin
                    r.value = VAL_W'(row_amt[idx]);
                    r.found = 1'b1;
                    for (int i = idx; i < rows_used - 1; i++) begin
                        row_src[i] = row_src[i + 1];
                        row_dst[i] = row_dst[i + 1];
                        row_amt[i] = row_amt[i + 1];
                    end
                    rows_used--;
                end
            end
            OP_LOOKUP: begin
                idx = find_pair_row(src, dst);
                if (idx >= 0) begin
                    r.value = VAL_W'(row_amt[idx]);
                    r.found = 1'b1;
                end else begin
                    r.value = VAL_NOT_FOUND;
                end
            end
            OP_SUM_SRC, OP_SUM_DST: begin
                total = '0;
                for (int i = 0; i < rows_used; i++) begin
                    match = (op == OP_SUM_SRC) ? (row_src[i] == src) : (row_dst[i] == dst);
                    if (match) begin
                        r.found = 1'b1;
                        total   = total + row_amt[i];
                        if (total > SUM_MAX)
                            total = SUM_MAX;
                    end
                end
                r.value = total;
            end
            OP_LIST_SRC, OP_LIST_DST: begin
                // hold each match back one step so the final one can carry last
                for (int i = 0; i < rows_used; i++) begin
                    match = (op == OP_LIST_SRC) ? (row_src[i] == src) : (row_dst[i] == dst);
                    if (match) begin
                        if (have_prev)
                            queue_reply(prev);
                        prev          = '0;
                        prev.item_src = row_src[i];
                        prev.item_dst = row_dst[i];
                        prev.item_amt = row_amt[i];
                        prev.found    = 1'b1;
                        have_prev     = 1'b1;
                    end
                end
                if (have_prev) begin
                    prev.last = 1'b1;
                    r         = prev;
                end
            end
            default: begin
            end
        endcase
        queue_reply(r);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_reply(input logic [OUT_DATA_W-1:0] data, input logic tlast);
        t_reply got;
        t_reply want;
        got.value    = data[25:0];
        got.item_src = data[33:26];
        got.item_dst = data[41:34];
        got.item_amt = data[61:42];
        got.found    = data[62];
        got.status   = data[63];
        got.last     = tlast;
        if (pending_replies.size() == 0) begin
            $display("%0t: result with nothing outstanding, expected none, %s %h last %b",
                     $time, "actual data", data, tlast);
            mismatches++;
        end else begin
            want = pending_replies.pop_front();
            compare_field("value", want.value, got.value);
            compare_field("item_source", want.item_src, got.item_src);
            compare_field("item_dest", want.item_dst, got.item_dst);
            compare_field("item_amount", want.item_amt, got.item_amt);
            compare_field("found", want.found, got.found);
            compare_field("last", want.last, got.last);
            compare_field("status", want.status, got.status);
        end
    endtask

    // results are checked before the request of the same edge is applied
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_used = 0;
            pending_replies.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_reply(i_m_tdata, i_m_tlast);
            if (i_s_tvalid && i_s_tready)
                apply_table_request(i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8],
                                    i_s_tdata[31:16]);
        end
        o_pending_count <= pending_replies.size();
        o_fail_count    <= mismatches;
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import pkat_pkg::*;

    localparam int                  WATCHDOG_LIMIT   = 2000;
    localparam int                  TAIL_CYCLES      = 40;
    localparam int                  IDLE_PERCENT     = 19;
    localparam int                  RX_STEADY_FIRST  = 300;
    localparam int                  RX_STEADY_LAST   = 700;
    localparam logic [3:0]          OP_UNKNOWN_FIRST = 4'd9;
    localparam logic [3:0]          OP_UNKNOWN_LAST  = 4'd15;
    localparam logic [ID_W-1:0]     ID_LOW           = '0;
    localparam logic [ID_W-1:0]     ID_HIGH          = '1;
    localparam logic [AMT_IN_W-1:0] AMT_ZERO         = '0;
    localparam logic [AMT_IN_W-1:0] AMT_FULL         = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    int                    fail_count;
    int                    pending_count;
    int                    quiet_cycles = 0;
    int                    rx_cycle = 0;
    logic                  steady_tx;
    logic [ID_W-1:0]       id_pool [4];

    pair_keyed_accumulate_table dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    pkat_result_check u_result_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tlast       (m_tlast),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side back-pressure, with one window of constant ready
    always @(negedge clk) begin
        if (rx_cycle >= RX_STEADY_FIRST && rx_cycle <= RX_STEADY_LAST)
            m_tready = 1'b1;
        else
            m_tready = ($urandom_range(0, 99) >= IDLE_PERCENT);
        rx_cycle++;
    end

    // no handshake on either side for too long means the block is stuck
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("pair_keyed_accumulate_table regression: fail");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic [3:0]          op,
                                input logic [ID_W-1:0]     src,
                                input logic [ID_W-1:0]     dst,
                                input logic [AMT_IN_W-1:0] amt);
        while (!steady_tx && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {amt, dst, src};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // mostly a few recurring ids so that pairs collide
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) == 0)
            return ID_W'($urandom_range(0, 255));
        return id_pool[$urandom_range(0, 3)];
    endfunction

    function automatic logic [AMT_IN_W-1:0] pick_amount();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return AMT_ZERO;
        if (roll == 1)
            return AMT_FULL;
        return AMT_IN_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [3:0] pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)  return OP_CLEAR;
        if (roll < 30) return OP_ADD;
        if (roll < 45) return OP_APPEND;
        if (roll < 58) return OP_REMOVE;
        if (roll < 68) return OP_LOOKUP;
        if (roll < 76) return OP_SUM_SRC;
        if (roll < 84) return OP_SUM_DST;
        if (roll < 90) return OP_LIST_SRC;
        if (roll < 96) return OP_LIST_DST;
        return 4'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
    endfunction

    initial begin
        logic [ID_W-1:0] s_id;
        logic [ID_W-1:0] d_id;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        steady_tx = 1'b0;
        for (int k = 0; k < 4; k++)
            id_pool[k] = ID_W'($urandom_range(0, 255));
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, merge, duplicates, unknown codes
        send_request(OP_LIST_SRC, ID_LOW, ID_LOW, AMT_ZERO);
        send_request(OP_LOOKUP, ID_HIGH, ID_HIGH, AMT_ZERO);
        send_request(OP_SUM_SRC, ID_LOW, ID_HIGH, AMT_FULL);
        send_request(OP_REMOVE, ID_HIGH, ID_HIGH, AMT_ZERO);
        send_request(OP_ADD, ID_HIGH, ID_HIGH, AMT_FULL);
        send_request(OP_ADD, ID_HIGH, ID_HIGH, AMT_FULL);
        send_request(OP_APPEND, ID_HIGH, ID_HIGH, AMT_FULL);
        send_request(OP_ADD, ID_LOW, ID_LOW, AMT_ZERO);
        send_request(OP_APPEND, ID_LOW, ID_HIGH, pick_amount());
        send_request(OP_LOOKUP, ID_HIGH, ID_HIGH, AMT_ZERO);
        send_request(OP_LOOKUP, ID_LOW, ID_LOW, AMT_FULL);
        send_request(OP_SUM_SRC, ID_HIGH, ID_LOW, AMT_ZERO);
        send_request(OP_SUM_DST, ID_LOW, ID_HIGH, AMT_ZERO);
        send_request(OP_LIST_SRC, ID_HIGH, ID_LOW, AMT_ZERO);
        send_request(OP_LIST_DST, ID_LOW, ID_HIGH, AMT_ZERO);
        send_request(OP_UNKNOWN_FIRST, ID_HIGH, ID_HIGH, AMT_FULL);
        send_request(OP_UNKNOWN_LAST, ID_LOW, ID_LOW, AMT_ZERO);
        send_request(OP_REMOVE, ID_HIGH, ID_HIGH, AMT_ZERO);
        send_request(OP_LIST_SRC, ID_HIGH, ID_LOW, AMT_ZERO);
        send_request(OP_REMOVE, ID_LOW, ID_HIGH, AMT_ZERO);
        send_request(OP_CLEAR, ID_HIGH, ID_HIGH, AMT_FULL);
        send_request(OP_SUM_DST, ID_LOW, ID_HIGH, AMT_ZERO);
        send_request(OP_LIST_DST, ID_LOW, ID_LOW, AMT_ZERO);

        // fill past the depth, then probe a full table
        send_request(OP_CLEAR, pick_id(), pick_id(), pick_amount());
        repeat (DEPTH + 1)
            send_request(OP_APPEND, pick_id(), pick_id(), pick_amount());
        repeat (3)
            send_request(OP_ADD, pick_id(), pick_id(), pick_amount());
        repeat (8)
            send_request(4'($urandom_range(OP_LOOKUP, OP_LIST_DST)), pick_id(), pick_id(),
                         pick_amount());
        repeat (4)
            send_request(OP_REMOVE, pick_id(), pick_id(), pick_amount());
        repeat (2)
            send_request(OP_APPEND, pick_id(), pick_id(), pick_amount());

        // drive one pair into amount saturation
        send_request(OP_CLEAR, pick_id(), pick_id(), pick_amount());
        s_id = pick_id();
        d_id = pick_id();
        repeat (18)
            send_request(OP_ADD, s_id, d_id, AMT_IN_W'($urandom_range(16'hF800, 16'hFFFF)));
        send_request(OP_LOOKUP, s_id, d_id, pick_amount());
        send_request(OP_SUM_SRC, s_id, pick_id(), pick_amount());
        send_request(OP_LIST_SRC, s_id, pick_id(), pick_amount());

        // mixed traffic over the recurring ids, one stretch without sender gaps
        for (int k = 0; k < 34; k++) begin
            steady_tx = (k >= 10 && k < 25);
            send_request(pick_op(), pick_id(), pick_id(), pick_amount());
        end
        steady_tx = 1'b0;
        s_tvalid  = 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("pair_keyed_accumulate_table regression: pass");
        else
            $display("pair_keyed_accumulate_table regression: fail");
        $finish;
    end

endmodule

FILE: files.f
design/pkat_pkg.sv
design/pkat_cell.sv
design/pkat_row.sv
design/pair_keyed_accumulate_table.sv
design/pkat_checker.sv
verif/pkat_result_check.sv
verif/tb.sv
